// File: src/apd_pkg.sv
// ----------------------------------------------------------------------------
// apd_pkg: shared types and constants for the ASCII packet deframer
// Holds the framing byte codes, the hex character decoder and the result
// record passed from the parser to the output buffer.
// ----------------------------------------------------------------------------
package apd_pkg;

	// Framing and decoding constants.
	localparam logic [7:0] SOH_BYTE      = 8'h01;
	localparam logic [7:0] EOT_BYTE      = 8'h04;
	localparam logic [7:0] LETTER_ABOVE  = 8'h40;
	localparam logic [3:0] LETTER_OFFSET = 4'h9;

	// Result kinds.
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// One result request as it leaves the parser.
	typedef struct packed {
		logic       result_kind;
		logic [7:0] data_byte;
		logic [7:0] packet_type;
		logic [7:0] declared_length;
		logic [7:0] received_length;
		logic       header_complete;
	} apd_result_t;

	// Decode one ASCII hex character; letters above 0x40 add nine modulo 16.
	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [3:0] n;
		n = c[3:0];
		if (c > LETTER_ABOVE) begin
			n = n + LETTER_OFFSET;
		end
		return n;
	endfunction

endpackage

// File: src/apd_parse.sv
// ----------------------------------------------------------------------------
// apd_parse: framing state machine
// Walks through hunt, type, length, STX and payload phases for each byte
// presented on the step strobe and forms at most one result per byte.
// ----------------------------------------------------------------------------
module apd_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           rx_byte,
	output logic                 res_valid,
	output apd_pkg::apd_result_t res
);
	import apd_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT   = 3'd0,
		PH_TYPE   = 3'd1,
		PH_LEN_HI = 3'd2,
		PH_LEN_LO = 3'd3,
		PH_STX    = 3'd4,
		PH_DATA   = 3'd5
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] held_type_q, held_type_d;
	logic [7:0] held_length_q, held_length_d;
	logic [7:0] payload_count_q, payload_count_d;
	logic       has_result;
	logic       is_eot;
	logic [7:0] count_inc;

	assign is_eot    = (rx_byte == EOT_BYTE);
	assign count_inc = payload_count_q + 8'd1;

	// Next state and result for the byte on the input.
	always_comb begin
		phase_d         = phase_q;
		held_type_d     = held_type_q;
		held_length_d   = held_length_q;
		payload_count_d = payload_count_q;
		has_result      = 1'b0;
		res             = '0;
		res.packet_type     = held_type_q;
		res.declared_length = held_length_q;
		res.received_length = payload_count_q;
		if (phase_q != PH_HUNT && is_eot) begin
			// End of packet; the header is complete only once payload began.
			has_result          = 1'b1;
			res.result_kind     = KIND_END;
			res.header_complete = (phase_q == PH_DATA);
			phase_d             = PH_HUNT;
		end else begin
			unique case (phase_q)
				PH_TYPE: begin
					held_type_d = rx_byte;
					phase_d     = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					held_length_d = {hex_nibble(rx_byte), 4'h0};
					phase_d       = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					held_length_d = {held_length_q[7:4], hex_nibble(rx_byte)};
					phase_d       = PH_STX;
				end
				PH_STX: begin
					phase_d = PH_DATA;
				end
				PH_DATA: begin
					// Payload bytes beyond the declared count are dropped.
					if (payload_count_q < held_length_q) begin
						payload_count_d     = count_inc;
						has_result          = 1'b1;
						res.result_kind     = KIND_DATA;
						res.data_byte       = rx_byte;
						res.received_length = count_inc;
						res.header_complete = 1'b1;
					end
				end
				default: begin
					// Hunting: only a start byte opens a packet.
					if (rx_byte == SOH_BYTE) begin
						held_type_d     = '0;
						held_length_d   = '0;
						payload_count_d = '0;
						phase_d         = PH_TYPE;
					end else begin
						phase_d = PH_HUNT;
					end
				end
			endcase
		end
	end

	assign res_valid = step && has_result;

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_HUNT;
			held_type_q     <= '0;
			held_length_q   <= '0;
			payload_count_q <= '0;
		end else if (step) begin
			phase_q         <= phase_d;
			held_type_q     <= held_type_d;
			held_length_q   <= held_length_d;
			payload_count_q <= payload_count_d;
		end
	end

	// The payload count never runs past the declared length.
	assert property (@(posedge clk) disable iff (!arst_n)
		payload_count_q <= held_length_q)
		else $error("payload count exceeds declared length");

	// A data result only comes out of the payload phase.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.result_kind == KIND_DATA |-> phase_q == PH_DATA)
		else $error("data result outside payload phase");

	// A start byte while hunting opens a fresh packet.
	assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_HUNT && rx_byte == SOH_BYTE
		|=> phase_q == PH_TYPE && payload_count_q == 8'd0 && held_type_q == 8'd0)
		else $error("start byte did not open a packet");

endmodule

// File: src/apd_out_buf.sv
// ----------------------------------------------------------------------------
// apd_out_buf: result register with skid stage
// Holds results for the output channel so that a stalled consumer does not
// stop the parser until both entries are full.
// ----------------------------------------------------------------------------
module apd_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  apd_pkg::apd_result_t push_data,
	output logic                 space,
	output logic                 out_valid,
	input  logic                 out_ready,
	output apd_pkg::apd_result_t out_data
);
	import apd_pkg::*;

	logic        out_valid_q;
	apd_result_t out_q;
	logic        skid_valid_q;
	apd_result_t skid_q;
	logic        pop;

	assign pop       = out_valid_q && out_ready;
	assign space     = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || pop) begin
			out_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (!out_valid_q || pop) begin
			if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	// The skid entry is only ever occupied behind a full output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid with empty output register");

	// No request arrives when both entries are full.
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_valid_q)
		else $error("result request lost on full buffer");

	// A drained output register refills from the skid entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && pop |=> out_valid_q && !skid_valid_q)
		else $error("skid entry not moved forward");

endmodule

// File: src/ascii_packet_deframer_unit.sv
// ----------------------------------------------------------------------------
// ascii_packet_deframer_unit: SOH/STX/EOT packet deframer
// Parses a received byte stream and emits one request per payload byte within
// the declared length, plus an end request with type, declared and received lengths.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_ready    rx_byte
//   out      out_valid / out_ready  result_kind, data_byte, packet_type,
//                                   declared_length, received_length,
//                                   header_complete
//
// One byte is accepted per cycle while in_ready is high. Its accepting edge loads
// the input register; the parser forms the request from it, and the request is
// registered in the result register, or in the skid register while that one is held.
// The parser has a single phase register, so each byte is done in one pass.
// Reset clears the parser to hunting and empties both buffer stages.
// A stalled output fills the result and skid registers; once the input register
// also holds a byte, in_ready drops until the consumer takes a request.
// ----------------------------------------------------------------------------
module ascii_packet_deframer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       result_kind,
	output logic [7:0] data_byte,
	output logic [7:0] packet_type,
	output logic [7:0] declared_length,
	output logic [7:0] received_length,
	output logic       header_complete
);
	import apd_pkg::*;

	logic        valid_s1;
	logic [7:0]  rx_byte_s1;
	logic        space;
	logic        advance;
	logic        res_valid;
	apd_result_t res;
	apd_result_t out_data;

	assign advance  = valid_s1 && space;
	assign in_ready = !valid_s1 || space;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	apd_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.rx_byte   (rx_byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	apd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Result fields to ports.
	assign result_kind     = out_data.result_kind;
	assign data_byte       = out_data.data_byte;
	assign packet_type     = out_data.packet_type;
	assign declared_length = out_data.declared_length;
	assign received_length = out_data.received_length;
	assign header_complete = out_data.header_complete;

endmodule

// File: dv/ascii_packet_deframer_unit_test.sv
// ----------------------------------------------------------------------------
// ascii_packet_deframer_unit_test: self-checking bench for the packet deframer
// Feeds framed byte streams and noise into the deframer and predicts every
// data and end-of-packet request in step with the accepted bytes. Each request
// the block returns is compared field by field with the oldest prediction.
// Random idling on both channels, a long output hold-off and drained pauses
// between phases exercise backpressure.
// ----------------------------------------------------------------------------
module ascii_packet_deframer_unit_test;
	import apd_pkg::*;

	// Run control.
	localparam int RANDOM_ITEMS = 1950;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 2000;
	localparam int SETTLE_CYCLES = 10;
	localparam int MAX_REPORTS  = 40;

	// ASCII bases used to spell hex length characters.
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;

	// Parser steps of the predictor.
	typedef enum logic [2:0] {
		SEEK_SOH,
		TAKE_TYPE,
		TAKE_LEN_HI,
		TAKE_LEN_LO,
		SKIP_STX,
		TAKE_DATA
	} frame_step_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       result_kind;
	logic [7:0] data_byte;
	logic [7:0] packet_type;
	logic [7:0] declared_length;
	logic [7:0] received_length;
	logic       header_complete;

	// Stimulus and prediction stores.
	logic [7:0]  pending_bytes[$];
	apd_result_t predicted_requests[$];

	// Predictor state.
	frame_step_t frame_step = SEEK_SOH;
	logic [7:0]  cur_type = 8'h00;
	logic [7:0]  cur_length = 8'h00;
	logic [7:0]  cur_count = 8'h00;

	int   sender_idle_pct = 0;
	int   rx_stall_pct = 0;
	bit   long_hold_due = 1'b0;
	bit   rx_hold = 1'b0;
	logic byte_taken = 1'b0;
	int   error_count = 0;
	int   idle_cycles = 0;

	ascii_packet_deframer_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.result_kind     (result_kind),
		.data_byte       (data_byte),
		.packet_type     (packet_type),
		.declared_length (declared_length),
		.received_length (received_length),
		.header_complete (header_complete)
	);

	// Free-running clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Decode one length character; letters wrap nine higher in four bits.
	function automatic logic [3:0] ascii_to_nibble(input logic [7:0] ch);
		logic [3:0] nib;
		nib = ch[3:0];
		if (ch > LETTER_ABOVE) begin
			nib = nib + LETTER_OFFSET;
		end
		return nib;
	endfunction

	// Advance the predicted parser by one byte and queue any request it makes.
	function automatic void deframe_byte(input logic [7:0] b);
		apd_result_t rec;
		rec = '0;
		if (frame_step == SEEK_SOH) begin
			if (b == SOH_BYTE) begin
				cur_type = 8'h00;
				cur_length = 8'h00;
				cur_count = 8'h00;
				frame_step = TAKE_TYPE;
			end
		end else if (b == EOT_BYTE) begin
			rec.result_kind = KIND_END;
			rec.packet_type = cur_type;
			rec.declared_length = cur_length;
			rec.received_length = cur_count;
			rec.header_complete = (frame_step == TAKE_DATA);
			predicted_requests.push_back(rec);
			frame_step = SEEK_SOH;
		end else begin
			case (frame_step)
				TAKE_TYPE: begin
					cur_type = b;
					frame_step = TAKE_LEN_HI;
				end
				TAKE_LEN_HI: begin
					cur_length = {ascii_to_nibble(b), 4'h0};
					frame_step = TAKE_LEN_LO;
				end
				TAKE_LEN_LO: begin
					cur_length[3:0] = ascii_to_nibble(b);
					frame_step = SKIP_STX;
				end
				SKIP_STX: begin
					frame_step = TAKE_DATA;
				end
				default: begin
					// Bytes past the declared count are dropped.
					if (cur_count < cur_length) begin
						cur_count = cur_count + 8'd1;
						rec.result_kind = KIND_DATA;
						rec.data_byte = b;
						rec.packet_type = cur_type;
						rec.declared_length = cur_length;
						rec.received_length = cur_count;
						rec.header_complete = 1'b1;
						predicted_requests.push_back(rec);
					end
				end
			endcase
		end
	endfunction

	task automatic report_mismatch(input string msg);
		if (error_count < MAX_REPORTS) begin
			$display("mismatch at %0t: %s", $time, msg);
		end
		error_count++;
	endtask

	task automatic compare_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
		end
	endtask

	// Spell a nibble as a hex character, in either case, sometimes as junk.
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] ch;
		if ($urandom_range(19) == 0) begin
			ch = 8'($urandom_range(255));
		end else if (nib < 4'd10) begin
			ch = CH_ZERO + nib;
		end else if ($urandom_range(1) == 1) begin
			ch = CH_UPPER_A + nib - 8'd10;
		end else begin
			ch = CH_LOWER_A + nib - 8'd10;
		end
		return ch;
	endfunction

	// Queue one framed packet; a cut packet ends early with EOT.
	task automatic queue_packet(input bit cut_short, output int n_added);
		logic [7:0] pkt[$];
		logic [7:0] b;
		int len, n_data, r, k, cut;
		pkt.push_back(SOH_BYTE);
		b = 8'($urandom_range(255));
		pkt.push_back(b);
		// Mostly short payloads, now and then any length up to the maximum.
		len = ($urandom_range(99) < 4) ? $urandom_range(255) : $urandom_range(12);
		pkt.push_back(hex_char(len[7:4]));
		pkt.push_back(hex_char(len[3:0]));
		b = ($urandom_range(1) == 1) ? 8'h02 : 8'($urandom_range(255));
		pkt.push_back(b);
		r = $urandom_range(9);
		if (r < 6) begin
			n_data = len;
		end else if (r < 8) begin
			n_data = len + $urandom_range(1, 3);
		end else begin
			n_data = (len > 0) ? $urandom_range(len - 1) : 0;
		end
		for (k = 0; k < n_data; k++) begin
			b = 8'($urandom_range(255));
			if (b == EOT_BYTE) begin
				b = b ^ 8'h80;
			end
			pkt.push_back(b);
		end
		// A cut lands either in the header or somewhere in the payload.
		if (cut_short) begin
			if (pkt.size() == 5 || $urandom_range(1) == 1) begin
				cut = $urandom_range(1, 4);
			end else begin
				cut = $urandom_range(5, pkt.size() - 1);
			end
			while (pkt.size() > cut) begin
				void'(pkt.pop_back());
			end
		end
		pkt.push_back(EOT_BYTE);
		n_added = pkt.size();
		foreach (pkt[i]) begin
			pending_bytes.push_back(pkt[i]);
		end
	endtask

	// Mix of whole packets, cut packets and noise between packets.
	task automatic queue_traffic(input int n_items);
		logic [7:0] b;
		int sent, r, k, n;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(99);
			if (r < 10) begin
				n = $urandom_range(1, 4);
				for (k = 0; k < n; k++) begin
					b = 8'($urandom_range(255));
					pending_bytes.push_back(b);
				end
			end else begin
				queue_packet(r < 20, n);
				sent += n;
			end
		end
	endtask

	// Wait until every queued byte is taken and every request has come back.
	task automatic drain_all;
		while (pending_bytes.size() != 0 || in_valid || predicted_requests.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items);
		sender_idle_pct = idle_pct;
		rx_stall_pct = stall_pct;
		queue_traffic(n_items);
		drain_all();
	endtask

	// Input driver: offers the next queued byte once the last one is taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || byte_taken) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					in_valid <= 1'b1;
					rx_byte <= pending_bytes.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Monitor: checks returned requests, then predicts from the accepted byte.
	always @(posedge clk or negedge arst_n) begin : monitor
		apd_result_t want;
		if (!arst_n) begin
			byte_taken <= 1'b0;
		end else begin
			byte_taken <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (predicted_requests.size() == 0) begin
					report_mismatch($sformatf("unexpected request, kind %0b type %0h",
						result_kind, packet_type));
				end else begin
					want = predicted_requests.pop_front();
					compare_field("result_kind", 8'(result_kind), 8'(want.result_kind));
					compare_field("data_byte", data_byte, want.data_byte);
					compare_field("packet_type", packet_type, want.packet_type);
					compare_field("declared_length", declared_length, want.declared_length);
					compare_field("received_length", received_length, want.received_length);
					compare_field("header_complete", 8'(header_complete),
						8'(want.header_complete));
				end
			end
			if (in_valid && in_ready) begin
				deframe_byte(rx_byte);
			end
		end
	end

	// Long output hold-off while the sender keeps offering bytes.
	initial begin
		wait (long_hold_due);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
	end

	// Watchdog on cycles without any handshake.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin : stimulus
		// Early EOT in every header slot, letter wrap, zero length,
		// SOH as payload and a dropped extra byte.
		logic [7:0] directed_bytes [29] = '{
			SOH_BYTE, EOT_BYTE,
			SOH_BYTE, 8'hFF, EOT_BYTE,
			SOH_BYTE, 8'h7F, 8'h61, EOT_BYTE,
			SOH_BYTE, 8'h00, 8'h46, 8'h66, EOT_BYTE,
			SOH_BYTE, SOH_BYTE, 8'h40, 8'h47, 8'h00, EOT_BYTE,
			SOH_BYTE, 8'h80, 8'h30, 8'h32, 8'h02, 8'hFF, SOH_BYTE, 8'h00, EOT_BYTE
		};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_bytes[i]) begin
			pending_bytes.push_back(directed_bytes[i]);
		end
		drain_all();

		run_phase(0, 0, RANDOM_ITEMS / 4);
		run_phase(74, 0, RANDOM_ITEMS / 4);
		long_hold_due = 1'b1;
		run_phase(0, 74, RANDOM_ITEMS / 4);
		run_phase(15, 15, RANDOM_ITEMS / 4);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
